// ----- rtl/core/multi_stack_shared_pool_defines.svh -----
// ---------------------------------------------------------------------------
// multi_stack_shared_pool assertion macros
// shared concurrent assertion forms for the block checker
// ---------------------------------------------------------------------------
`ifndef MULTI_STACK_SHARED_POOL_DEFINES_SVH
`define MULTI_STACK_SHARED_POOL_DEFINES_SVH

// same-cycle implication
`define MSSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mssp assertion failed");

// next-cycle implication
`define MSSP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mssp assertion failed");

`endif

// ----- rtl/core/mssp_pkg.sv -----
// ----------------------------------------------------------------------------
// mssp_pkg
// types and constants for the multi-stack shared-pool block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mssp_pkg;

  localparam int NUM_STACKS_DEF = 8;
  localparam int SLOTS_DEF      = 64;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RD   = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [2:0]         stack_id;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] pop_value;
  } out_t;

endpackage

// ----- rtl/core/multi_stack_shared_pool.sv -----
// ----------------------------------------------------------------------------
// multi_stack_shared_pool
// several lifo stacks sharing one pool of slots, linked through a free chain
// ----------------------------------------------------------------------------
// usage
//   input: a transaction is taken on a rising edge with start high and busy
//   low; in_item carries cmd (push/pop), stack_id and push_value
//   output: out_valid is high for exactly one cycle with out_item holding the
//   status and the popped value; the receiver cannot stall it
//   timing: busy rises the cycle after accept; the pool memory read is
//   registered on accept, the same slot is written back in the read state,
//   and the result is registered from there; start is taken again in the
//   cycle the result shows, so a new transaction waits until the last is done
//   reset: all stacks empty, free chain covers every slot in order; the link
//   memory is not swept, a fill mark tells which slots hold a written link,
//   so the block is ready in the first cycle after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_stack_shared_pool
  import mssp_pkg::*;
#(
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int SLOTS      = SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  localparam int LW  = $clog2(SLOTS + 1);
  localparam int SW  = $clog2(SLOTS);
  localparam int SIW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int EW  = 32 + LW;
  localparam logic [LW-1:0] LINK_NULL = LW'(SLOTS);

  logic [EW-1:0] pool_mem [SLOTS];
  logic [EW-1:0] rdata_r;

  state_t state_r, state_nxt;
  logic [LW-1:0] top_r [NUM_STACKS];
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [LW-1:0] wm_r, wm_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_item_r, out_item_nxt;

  cmd_t               cmd_r;
  logic [SIW-1:0]     sidx_r;
  logic signed [31:0] val_r;
  logic [LW-1:0]      slot_r;
  logic [LW-1:0]      otop_r;
  logic               fail_r;

  logic           accept;
  logic           sid_ok;
  logic [SIW-1:0] sidx;
  logic [LW-1:0]  top_sel;
  logic [LW-1:0]  slot_sel;
  logic           fail;
  logic [LW-1:0]  link_rd;
  logic           mem_we;
  logic [EW-1:0]  mem_wdata;
  logic           top_we;
  logic [LW-1:0]  top_wdata;

  assign accept   = start && (state_r == S_IDLE);
  assign sid_ok   = int'(in_item.stack_id) < NUM_STACKS;
  assign sidx     = SIW'(in_item.stack_id);
  assign top_sel  = sid_ok ? top_r[sidx] : LINK_NULL;
  assign slot_sel = (in_item.cmd == CMD_POP) ? top_sel : free_head_r;
  assign fail     = !sid_ok || (slot_sel == LINK_NULL);

  // slots at or above the fill mark still hold their reset link i+1
  assign link_rd = (slot_r < wm_r) ? rdata_r[LW-1:0] : LW'(slot_r + LW'(1));

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= pool_mem[slot_sel[SW-1:0]];
    end
    if (mem_we) begin
      pool_mem[slot_r[SW-1:0]] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_item.cmd;
      sidx_r <= sidx;
      val_r  <= in_item.push_value;
      slot_r <= slot_sel;
      otop_r <= top_sel;
      fail_r <= fail;
    end
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      wm_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        top_r[i] <= LINK_NULL;
      end
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      wm_r        <= wm_nxt;
      out_valid_r <= out_valid_nxt;
      if (top_we) begin
        top_r[sidx_r] <= top_wdata;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    free_head_nxt = free_head_r;
    wm_nxt        = wm_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_wdata     = rdata_r;
    top_we        = 1'b0;
    top_wdata     = link_rd;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt               = S_IDLE;
        out_valid_nxt           = 1'b1;
        out_item_nxt.pop_value  = '0;
        if (fail_r) begin
          out_item_nxt.status = (cmd_r == CMD_PUSH) ? ST_OVERFLOW : ST_UNDERFLOW;
        end else begin
          out_item_nxt.status = ST_OK;
          mem_we              = 1'b1;
          top_we              = 1'b1;
          if (cmd_r == CMD_PUSH) begin
            mem_wdata     = {val_r, otop_r};
            top_wdata     = slot_r;
            free_head_nxt = link_rd;
            if (slot_r == wm_r) begin
              wm_nxt = LW'(wm_r + LW'(1));
            end
          end else begin
            mem_wdata              = {rdata_r[EW-1:LW], free_head_r};
            top_wdata              = link_rd;
            free_head_nxt          = slot_r;
            out_item_nxt.pop_value = rdata_r[EW-1:LW];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/core/mssp_checker.sv -----
// ----------------------------------------------------------------------------
// mssp_checker
// port-level checks on the multi-stack shared-pool block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_stack_shared_pool_defines.svh"

module mssp_checker
  import mssp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_item
);

  `MSSP_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)
  `MSSP_ASSERT_IMP(a_result_two_after, start && !busy, ##2 out_valid)
  `MSSP_ASSERT_IMP(a_idle_with_result, out_valid, !busy)
  `MSSP_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  `MSSP_ASSERT_IMP(a_fail_zero, out_valid && out_item.status != ST_OK, out_item.pop_value == 0)

endmodule

bind multi_stack_shared_pool mssp_checker u_mssp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
